FILE: rtl/core/sarq_pkg.sv
// ============================================================================
// sarq_pkg: shared types and constants of the segment transfer ARQ server
// Holds the request and result records, command codes, configuration
// register indexes and the state encoding of the execution engine.
// ============================================================================
package sarq_pkg;

  // Default values of the top-level parameters.
  localparam int unsigned TOTAL_SEGMENTS_DEF = 8;
  localparam int unsigned QUEUE_DEPTH_DEF    = 8;
  localparam int unsigned MAX_BOARD_DEF      = 8;

  // Results that one request may cause at most.
  localparam int unsigned MAX_RESULTS = 8;
  localparam int unsigned ResCntW     = $clog2(MAX_RESULTS);

  // Command codes of the cmd field.
  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_ACK  = 2'd1;
  localparam logic [1:0] CMD_TICK = 2'd2;

  // Configuration register indexes and reset values.
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] CFG_VALID_MASK  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_MAX_RETRIES = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_ACK_TIMEOUT = 2'd2;

  localparam logic [7:0]  VALID_MASK_RST  = 8'h00;
  localparam logic [3:0]  MAX_RETRIES_RST = 4'd3;
  localparam logic [15:0] ACK_TIMEOUT_RST = 16'd1000;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] req_board;
    logic [7:0] ack_source;
    logic [7:0] ack_seg;
    logic       ack_good;
  } sarq_req_t;

  typedef struct packed {
    logic [7:0] dest_board;
    logic [7:0] seg_number;
    logic [7:0] seg_total;
    logic       last;
  } sarq_res_t;

  typedef struct packed {
    logic [7:0]  valid_board_mask;
    logic [3:0]  max_retries;
    logic [15:0] ack_timeout_ticks;
  } sarq_cfg_t;

  // Classified command as it travels from the front end to the engine.
  typedef enum logic [1:0] {
    KIND_NOP,
    KIND_LOAD,
    KIND_ACK,
    KIND_TICK
  } sarq_kind_e;

  typedef struct packed {
    sarq_kind_e kind;
    logic [7:0] board;
    logic [7:0] seg;
    logic       good;
  } sarq_cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_DRAIN
  } sarq_state_e;

endpackage

FILE: rtl/core/segment_transfer_arq_server.sv
// ============================================================================
// segment_transfer_arq_server: stop-and-wait segment sender
// Serves board load requests, sends segments one at a time, waits for
// matching acknowledgements and retries on rejection or timeout.
// ============================================================================
// A request is taken at a rising clock edge where start_i is high and busy_o
// is low. busy_o rises only while the two-entry command queue between the
// intake and the execution engine is full. The engine works through one
// queued request per cycle while it is not draining the ring; when a request
// leaves the transfer idle with boards waiting in the ring, the engine then
// serves waiting boards, one per cycle and at most eight, before it takes
// the next request. Each result appears on res_o for exactly one cycle with
// res_valid_o high, starting the cycle after the engine handles the request;
// the receiver cannot stall results and must take each one as it comes.
// Results of one request come in back-to-back cycles, and the last of them
// carries last set. A request that causes no result gives no strobe at all.
// Configuration writes through cfg_we_i take effect at once and should only
// happen while no request is in progress.
module segment_transfer_arq_server #(
  parameter int unsigned TOTAL_SEGMENTS = sarq_pkg::TOTAL_SEGMENTS_DEF,
  parameter int unsigned QUEUE_DEPTH    = sarq_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned MAX_BOARD      = sarq_pkg::MAX_BOARD_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  sarq_pkg::sarq_req_t                req_i,
  output logic                               busy_o,
  output logic                               res_valid_o,
  output sarq_pkg::sarq_res_t                res_o,
  input  logic                               cfg_we_i,
  input  logic [sarq_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [sarq_pkg::CfgDataW-1:0]      cfg_wdata_i
);
  import sarq_pkg::*;

  sarq_cfg_t cfg_q, cfg_d;
  sarq_cmd_t front_cmd, fifo_cmd;
  logic      push, pop, fifo_valid, fifo_full;

  // Configuration registers; writes to an unused index are ignored.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_VALID_MASK:  cfg_d.valid_board_mask  = cfg_wdata_i[7:0];
        CFG_MAX_RETRIES: cfg_d.max_retries       = cfg_wdata_i[3:0];
        CFG_ACK_TIMEOUT: cfg_d.ack_timeout_ticks = cfg_wdata_i[15:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.valid_board_mask  <= VALID_MASK_RST;
      cfg_q.max_retries       <= MAX_RETRIES_RST;
      cfg_q.ack_timeout_ticks <= ACK_TIMEOUT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Intake: accepts and classifies requests.
  sarq_front #(
    .MAX_BOARD (MAX_BOARD)
  ) u_front (
    .start_i  (start_i),
    .req_i    (req_i),
    .q_full_i (fifo_full),
    .busy_o   (busy_o),
    .push_o   (push),
    .cmd_o    (front_cmd)
  );

  // Short command queue so intake and execution stall independently.
  sarq_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .pop_i   (pop),
    .valid_o (fifo_valid),
    .full_o  (fifo_full),
    .cmd_o   (fifo_cmd)
  );

  // Execution engine: protocol state, ring of waiting boards, result register.
  sarq_back #(
    .TOTAL_SEGMENTS (TOTAL_SEGMENTS),
    .QUEUE_DEPTH    (QUEUE_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (fifo_valid),
    .cmd_i       (fifo_cmd),
    .pop_o       (pop),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule

FILE: rtl/core/sarq_front.sv
// ============================================================================
// sarq_front: request intake and classification
// Accepts a request when the command queue has room and turns it into a
// classified command for the execution engine.
// ============================================================================
module sarq_front #(
  parameter int unsigned MAX_BOARD = sarq_pkg::MAX_BOARD_DEF
) (
  input  logic                 start_i,
  input  sarq_pkg::sarq_req_t  req_i,
  input  logic                 q_full_i,
  output logic                 busy_o,
  output logic                 push_o,
  output sarq_pkg::sarq_cmd_t  cmd_o
);
  import sarq_pkg::*;

  logic board_ok;

  assign busy_o   = q_full_i;
  assign push_o   = start_i && !q_full_i;
  assign board_ok = (req_i.req_board >= 8'd1) && (req_i.req_board <= 8'(MAX_BOARD));

  // Every accepted request goes on, even one without effect, because the
  // engine drains its ring at the end of each request.
  always_comb begin
    cmd_o.kind  = KIND_NOP;
    cmd_o.board = req_i.req_board;
    cmd_o.seg   = req_i.ack_seg;
    cmd_o.good  = req_i.ack_good;
    case (req_i.cmd)
      CMD_LOAD: begin
        if (board_ok) begin
          cmd_o.kind = KIND_LOAD;
        end
      end
      CMD_ACK: begin
        cmd_o.kind  = KIND_ACK;
        cmd_o.board = req_i.ack_source;
      end
      CMD_TICK: begin
        cmd_o.kind = KIND_TICK;
      end
      default: begin
        cmd_o.kind = KIND_NOP;
      end
    endcase
  end

endmodule

FILE: rtl/core/sarq_cmd_fifo.sv
// ============================================================================
// sarq_cmd_fifo: two-entry command queue
// Decouples request intake from the execution engine.
// ============================================================================
module sarq_cmd_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  sarq_pkg::sarq_cmd_t  cmd_i,
  input  logic                 pop_i,
  output logic                 valid_o,
  output logic                 full_o,
  output sarq_pkg::sarq_cmd_t  cmd_o
);
  import sarq_pkg::*;

  sarq_cmd_t  mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign valid_o = (cnt_q != 2'd0);
  assign full_o  = (cnt_q == 2'd2);
  assign cmd_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

FILE: rtl/core/sarq_back.sv
// ============================================================================
// sarq_back: transfer execution engine
// Runs the stop-and-wait protocol: segment sending, acknowledgement matching,
// timeout and retry handling, and the ring of waiting load requests.
// ============================================================================
module sarq_back #(
  parameter int unsigned TOTAL_SEGMENTS = sarq_pkg::TOTAL_SEGMENTS_DEF,
  parameter int unsigned QUEUE_DEPTH    = sarq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sarq_pkg::sarq_cfg_t  cfg_i,
  input  logic                 cmd_valid_i,
  input  sarq_pkg::sarq_cmd_t  cmd_i,
  output logic                 pop_o,
  output logic                 res_valid_o,
  output sarq_pkg::sarq_res_t  res_o
);
  import sarq_pkg::*;

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SumW = PtrW + 1;

  sarq_state_e state_q, state_d;

  logic               xfer_busy_q, xfer_busy_d;
  logic [7:0]         active_board_q, active_board_d;
  logic [7:0]         cur_seg_q, cur_seg_d;
  logic [3:0]         retry_q, retry_d;
  logic               armed_q, armed_d;
  logic [15:0]        left_q, left_d;
  logic [PtrW-1:0]    head_q, head_d;
  logic [CntW-1:0]    count_q, count_d;
  logic [ResCntW-1:0] res_cnt_q, res_cnt_d;
  logic [7:0]         ring_q [QUEUE_DEPTH];
  logic               ring_we;
  logic [PtrW-1:0]    tail;
  logic [SumW-1:0]    tail_sum;
  logic               res_vld_q, res_vld_d;
  sarq_res_t          res_q, res_d;

  assign tail_sum = SumW'(head_q) + SumW'(count_q);
  assign tail     = (tail_sum >= SumW'(QUEUE_DEPTH)) ? PtrW'(tail_sum - SumW'(QUEUE_DEPTH))
                                                     : PtrW'(tail_sum);

  always_comb begin : datapath
    logic       do_start;
    logic       do_send;
    logic       do_fail;
    logic [7:0] start_brd;
    logic [7:0] send_seg;
    logic [7:0] nseg;
    logic [3:0] nretry;
    logic       start_last;
    logic [2:0] bit_idx;

    xfer_busy_d    = xfer_busy_q;
    active_board_d = active_board_q;
    cur_seg_d      = cur_seg_q;
    retry_d        = retry_q;
    armed_d        = armed_q;
    left_d         = left_q;
    head_d         = head_q;
    count_d        = count_q;
    res_cnt_d      = res_cnt_q;
    res_vld_d      = 1'b0;
    res_d          = res_q;
    pop_o          = 1'b0;
    ring_we        = 1'b0;
    do_start       = 1'b0;
    do_send        = 1'b0;
    do_fail        = 1'b0;
    start_brd      = cmd_i.board;
    send_seg       = cur_seg_q;
    nseg           = cur_seg_q + 8'd1;
    nretry         = retry_q + 4'd1;
    start_last     = 1'b1;

    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          pop_o     = 1'b1;
          res_cnt_d = '0;
          case (cmd_i.kind)
            KIND_LOAD: begin
              if (xfer_busy_q || (count_q != '0)) begin
                if (count_q < CntW'(QUEUE_DEPTH)) begin
                  ring_we = 1'b1;
                  count_d = count_q + CntW'(1);
                end
              end else begin
                do_start = 1'b1;
              end
            end
            KIND_ACK: begin
              if (xfer_busy_q && (cmd_i.board == active_board_q) &&
                  (cmd_i.seg == cur_seg_q)) begin
                armed_d = 1'b0;
                left_d  = 16'd0;
                if (!cmd_i.good) begin
                  do_fail = 1'b1;
                end else begin
                  retry_d   = 4'd0;
                  cur_seg_d = nseg;
                  if (nseg >= 8'(TOTAL_SEGMENTS)) begin
                    xfer_busy_d = 1'b0;
                  end else begin
                    do_send  = 1'b1;
                    send_seg = nseg;
                  end
                end
              end
            end
            KIND_TICK: begin
              if (armed_q) begin
                if (left_q <= 16'd1) begin
                  left_d  = 16'd0;
                  armed_d = 1'b0;
                  do_fail = xfer_busy_q;
                end else begin
                  left_d = left_q - 16'd1;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_DRAIN: begin
        // One waiting request leaves the ring per cycle.
        start_brd  = ring_q[head_q];
        do_start   = 1'b1;
        head_d     = (head_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : head_q + PtrW'(1);
        count_d    = count_q - CntW'(1);
        res_cnt_d  = res_cnt_q + ResCntW'(1);
        start_last = (count_q == CntW'(1)) || (res_cnt_q == ResCntW'(MAX_RESULTS - 1));
      end
      default: begin
      end
    endcase

    if (do_fail) begin
      retry_d = nretry;
      if (nretry >= cfg_i.max_retries) begin
        xfer_busy_d = 1'b0;
      end else begin
        do_send  = 1'b1;
        send_seg = cur_seg_q;
      end
    end

    bit_idx = 3'(start_brd - 8'd1);
    if (do_start) begin
      if (!cfg_i.valid_board_mask[bit_idx]) begin
        res_vld_d        = 1'b1;
        res_d.dest_board = start_brd;
        res_d.seg_number = 8'd0;
        res_d.seg_total  = 8'd0;
        res_d.last       = start_last;
      end else begin
        active_board_d = start_brd;
        cur_seg_d      = 8'd0;
        retry_d        = 4'd0;
        xfer_busy_d    = 1'b1;
        do_send        = 1'b1;
        send_seg       = 8'd0;
      end
    end

    // A sent segment always leaves a transfer running, so it ends the request.
    if (do_send) begin
      res_vld_d        = 1'b1;
      res_d.dest_board = active_board_d;
      res_d.seg_number = send_seg;
      res_d.seg_total  = 8'(TOTAL_SEGMENTS);
      res_d.last       = 1'b1;
      armed_d          = 1'b1;
      left_d           = cfg_i.ack_timeout_ticks;
    end
  end

  always_comb begin : next_state
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (pop_o && !xfer_busy_d && (count_d != '0)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (xfer_busy_d || (count_d == '0) ||
            (res_cnt_q == ResCntW'(MAX_RESULTS - 1))) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      xfer_busy_q    <= 1'b0;
      active_board_q <= 8'd0;
      cur_seg_q      <= 8'd0;
      retry_q        <= 4'd0;
      armed_q        <= 1'b0;
      left_q         <= 16'd0;
      head_q         <= '0;
      count_q        <= '0;
      res_cnt_q      <= '0;
      res_vld_q      <= 1'b0;
    end else begin
      state_q        <= state_d;
      xfer_busy_q    <= xfer_busy_d;
      active_board_q <= active_board_d;
      cur_seg_q      <= cur_seg_d;
      retry_q        <= retry_d;
      armed_q        <= armed_d;
      left_q         <= left_d;
      head_q         <= head_d;
      count_q        <= count_d;
      res_cnt_q      <= res_cnt_d;
      res_vld_q      <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (ring_we) begin
      ring_q[tail] <= cmd_i.board;
    end
  end

  assign res_valid_o = res_vld_q;
  assign res_o       = res_q;

  // The acknowledgement timer only runs while a transfer is in flight.
  a_armed_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    armed_q |-> xfer_busy_q)
    else $error("timer armed without a transfer");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(QUEUE_DEPTH))
    else $error("ring count above depth");

  a_drain_cond: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN) |-> (!xfer_busy_q && (count_q != '0)))
    else $error("draining while busy or with an empty ring");

  // A result that is not the last of its request is followed at once.
  a_last_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_vld_q && !res_q.last) |=> res_vld_q)
    else $error("request ended without a last result");

endmodule

FILE: test/segment_transfer_arq_server_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// segment_transfer_arq_server_tb: self-checking regression of the ARQ server
// Drives load, acknowledgement and tick requests through the command port and
// changes the configuration between phases. A scoreboard predicts every
// segment message, and each strobed result is checked against it in order.
// ============================================================================
module segment_transfer_arq_server_tb;
  import sarq_pkg::*;

  localparam bit [7:0]    SEGS_PER_BOARD  = 8'(TOTAL_SEGMENTS_DEF);
  localparam int unsigned RING_DEPTH      = QUEUE_DEPTH_DEF;
  localparam int unsigned BOARD_COUNT     = MAX_BOARD_DEF;
  // The cmd field has one code that the block does not define.
  localparam logic [1:0]  CMD_UNUSED      = 2'd3;
  // Room for two queued requests, each with a full ring drain, plus pipeline slack.
  localparam int unsigned SETTLE_CYCLES   = 32;
  localparam int unsigned ITEMS_PER_PHASE = 46;
  localparam int unsigned CYCLE_LIMIT     = 200000;

  // The scoreboard keeps its own copy of the transfer state, the pending-board
  // ring and the configuration. Every accepted request is played against
  // that state, and the segment messages it causes are queued in order.
  class arq_scoreboard;
    bit [7:0]    board_mask;
    bit [3:0]    retry_limit;
    bit [15:0]   ack_ticks;
    bit          xfer_busy;
    bit [7:0]    cur_board;
    bit [7:0]    cur_seg;
    bit [3:0]    fail_count;
    bit          timer_on;
    bit [15:0]   ticks_left;
    bit [7:0]    waiting_boards [RING_DEPTH];
    int unsigned ring_rd;
    int unsigned ring_fill;
    sarq_res_t   step_segments[$];
    sarq_res_t   pending_segments[$];
    int          errors;

    function new();
      board_mask  = VALID_MASK_RST;
      retry_limit = MAX_RETRIES_RST;
      ack_ticks   = ACK_TIMEOUT_RST;
      xfer_busy   = 1'b0;
      cur_board   = '0;
      cur_seg     = '0;
      fail_count  = '0;
      timer_on    = 1'b0;
      ticks_left  = '0;
      ring_rd     = 0;
      ring_fill   = 0;
      errors      = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        CFG_VALID_MASK:  board_mask  = data[7:0];
        CFG_MAX_RETRIES: retry_limit = data[3:0];
        CFG_ACK_TIMEOUT: ack_ticks   = data;
        default: ;
      endcase
    endfunction

    // One request never produces more than MAX_RESULTS messages.
    function void emit(bit [7:0] board, bit [7:0] seg, bit [7:0] total);
      sarq_res_t msg;
      if (step_segments.size() >= MAX_RESULTS) return;
      msg.dest_board = board;
      msg.seg_number = seg;
      msg.seg_total  = total;
      msg.last       = 1'b0;
      step_segments.push_back(msg);
    endfunction

    function void send_segment();
      emit(cur_board, cur_seg, SEGS_PER_BOARD);
      timer_on   = 1'b1;
      ticks_left = ack_ticks;
    endfunction

    // A board without stored data only gets an empty reply.
    function void start_board(bit [7:0] board);
      bit [2:0] mask_bit;
      mask_bit = board[2:0] - 3'd1;
      if (!board_mask[mask_bit]) begin
        emit(board, 8'd0, 8'd0);
        return;
      end
      cur_board  = board;
      cur_seg    = '0;
      fail_count = '0;
      xfer_busy  = 1'b1;
      send_segment();
    endfunction

    // A limit of zero abandons on the first failure, as the compare shows.
    function void fail_attempt();
      fail_count = fail_count + 4'd1;
      if (fail_count >= retry_limit) begin
        xfer_busy = 1'b0;
        return;
      end
      send_segment();
    endfunction

    function void note_request(sarq_req_t req);
      bit [7:0]  board;
      sarq_res_t tail;
      step_segments.delete();
      case (req.cmd)
        CMD_LOAD: begin
          if (req.req_board >= 1 && req.req_board <= BOARD_COUNT) begin
            if (xfer_busy || ring_fill > 0) begin
              // A full ring drops the request without a trace.
              if (ring_fill < RING_DEPTH) begin
                waiting_boards[(ring_rd + ring_fill) % RING_DEPTH] = req.req_board;
                ring_fill++;
              end
            end else begin
              start_board(req.req_board);
            end
          end
        end
        CMD_ACK: begin
          if (xfer_busy && req.ack_source == cur_board && req.ack_seg == cur_seg) begin
            timer_on   = 1'b0;
            ticks_left = '0;
            if (!req.ack_good) begin
              fail_attempt();
            end else begin
              fail_count = '0;
              cur_seg    = cur_seg + 8'd1;
              if (cur_seg >= SEGS_PER_BOARD) xfer_busy = 1'b0;
              else send_segment();
            end
          end
        end
        CMD_TICK: begin
          // A timeout of zero expires on the first tick, like a timeout of one.
          if (timer_on) begin
            if (ticks_left <= 16'd1) begin
              ticks_left = '0;
              timer_on   = 1'b0;
              if (xfer_busy) fail_attempt();
            end else begin
              ticks_left = ticks_left - 16'd1;
            end
          end
        end
        default: ;
      endcase
      // An idle server works through waiting boards, at most MAX_RESULTS, until one starts a transfer.
      while (!xfer_busy && ring_fill > 0 && step_segments.size() < MAX_RESULTS) begin
        board     = waiting_boards[ring_rd];
        ring_rd   = (ring_rd + 1) % RING_DEPTH;
        ring_fill--;
        start_board(board);
      end
      if (step_segments.size() > 0) begin
        tail      = step_segments.pop_back();
        tail.last = 1'b1;
        step_segments.push_back(tail);
      end
      foreach (step_segments[i]) pending_segments.push_back(step_segments[i]);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_segment(sarq_res_t got);
      sarq_res_t want;
      if (pending_segments.size() == 0) begin
        errors++;
        $display("%0t: unexpected segment, expected none, %s %0d seg %0d total %0d last %0b",
                 $time, "actual dest", got.dest_board, got.seg_number, got.seg_total,
                 got.last);
        return;
      end
      want = pending_segments.pop_front();
      compare_field("dest_board", want.dest_board, got.dest_board);
      compare_field("seg_number", want.seg_number, got.seg_number);
      compare_field("seg_total", want.seg_total, got.seg_total);
      compare_field("last", 8'(want.last), 8'(got.last));
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start_i;
  sarq_req_t             req_i;
  logic                  busy_o;
  logic                  res_valid_o;
  sarq_res_t             res_o;
  logic                  cfg_we_i;
  logic [CfgIdxW-1:0]    cfg_idx_i;
  logic [CfgDataW-1:0]   cfg_wdata_i;

  arq_scoreboard sb;
  int unsigned   cycles = 0;

  segment_transfer_arq_server DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .req_i       (req_i),
    .busy_o      (busy_o),
    .res_valid_o (res_valid_o),
    .res_o       (res_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Results cannot be held off, so every strobe is checked at the edge that
  // ends its cycle.
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) sb.check_segment(res_o);
  end

  // The watchdog ends a hung run.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("segment_transfer_arq_server regression: fail");
      $finish;
    end
  end

  function automatic sarq_req_t mk(logic [1:0] cmd, logic [7:0] board, logic [7:0] src,
                                   logic [7:0] seg, logic good);
    sarq_req_t req;
    req.cmd        = cmd;
    req.req_board  = board;
    req.ack_source = src;
    req.ack_seg    = seg;
    req.ack_good   = good;
    return req;
  endfunction

  // Random requests follow the predicted state: while a transfer runs, most
  // requests are the acknowledgement it waits for, or ticks toward its timeout.
  // Some are loads of valid boards, and the rest keep fully random fields, which covers stray acknowledgements,
  // out-of-range boards and the undefined command.
  function automatic sarq_req_t next_request();
    sarq_req_t   req;
    int unsigned pick;
    req = mk(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
             8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
             1'($urandom_range(0, 1)));
    pick = $urandom_range(0, 99);
    if (sb.xfer_busy) begin
      if (pick < 50) begin
        req.cmd        = CMD_ACK;
        req.ack_source = sb.cur_board;
        req.ack_seg    = sb.cur_seg;
        req.ack_good   = ($urandom_range(0, 9) != 0);
      end else if (pick < 72) begin
        req.cmd = CMD_TICK;
      end else if (pick < 84) begin
        req.cmd       = CMD_LOAD;
        req.req_board = 8'($urandom_range(1, BOARD_COUNT));
      end
    end else begin
      if (pick < 55) begin
        req.cmd       = CMD_LOAD;
        req.req_board = 8'($urandom_range(1, BOARD_COUNT));
      end else if (pick < 65) begin
        req.cmd = CMD_TICK;
      end
    end
    return req;
  endfunction

  // Holds a request on the port until an edge sees start high and busy low.
  // start_i stays high afterwards, so back-to-back requests never lower it.
  task automatic put_request(sarq_req_t req);
    start_i <= 1'b1;
    req_i   <= req;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    sb.note_request(req);
  endtask

  // Waits until every predicted segment has been seen, then lets requests that
  // cause no message leave the command queue and the engine.
  task automatic settle();
    start_i <= 1'b0;
    while (sb.pending_segments.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apply_config(bit [7:0] mask, bit [3:0] retries, bit [15:0] ticks);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_VALID_MASK;
    cfg_wdata_i <= {8'h00, mask};
    @(posedge clk_i);
    sb.write_reg(CFG_VALID_MASK, {8'h00, mask});
    cfg_idx_i   <= CFG_MAX_RETRIES;
    cfg_wdata_i <= {12'h000, retries};
    @(posedge clk_i);
    sb.write_reg(CFG_MAX_RETRIES, {12'h000, retries});
    cfg_idx_i   <= CFG_ACK_TIMEOUT;
    cfg_wdata_i <= ticks;
    @(posedge clk_i);
    sb.write_reg(CFG_ACK_TIMEOUT, ticks);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin
    bit [7:0]  burst [11] = '{8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7, 8'd0, 8'd9,
                              8'd2, 8'd3, 8'd4};
    bit [7:0]  mask;
    bit [3:0]  retries;
    bit [15:0] ticks;

    sb          = new();
    rst_ni      <= 1'b0;
    start_i     <= 1'b0;
    req_i       <= '0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= CFG_VALID_MASK;
    cfg_wdata_i <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset configuration: no board has data. Out-of-range boards are ignored,
    // boards at both ends of the range get empty replies, and the undefined
    // command, an acknowledgement while idle and an unarmed tick do nothing.
    put_request(mk(CMD_LOAD, 8'd0, 8'h00, 8'h00, 1'b0));
    put_request(mk(CMD_LOAD, 8'd255, 8'hff, 8'hff, 1'b1));
    put_request(mk(CMD_LOAD, 8'd1, 8'h00, 8'h00, 1'b0));
    put_request(mk(CMD_LOAD, 8'd8, 8'hff, 8'hff, 1'b1));
    put_request(mk(CMD_UNUSED, 8'hff, 8'hff, 8'hff, 1'b1));
    put_request(mk(CMD_ACK, 8'h00, 8'hff, 8'hff, 1'b1));
    put_request(mk(CMD_TICK, 8'h00, 8'h00, 8'h00, 1'b0));
    settle();

    // Boards 1 and 8 have data, two failures abandon, two ticks time out.
    // Board 1 advances one segment, ignores acknowledgements from the wrong
    // board and for the wrong segment, and resends after a rejection. The
    // ring then fills with boards without data, one more request is dropped,
    // and the timeout that abandons board 1 drains the full ring at once.
    apply_config(8'h81, 4'd2, 16'd2);
    put_request(mk(CMD_LOAD, 8'd1, 8'h00, 8'h00, 1'b0));
    put_request(mk(CMD_ACK, 8'h00, 8'd1, 8'd0, 1'b1));
    put_request(mk(CMD_ACK, 8'h00, 8'd2, 8'd1, 1'b1));
    put_request(mk(CMD_ACK, 8'h00, 8'd1, 8'd5, 1'b1));
    put_request(mk(CMD_ACK, 8'h00, 8'd1, 8'd1, 1'b0));
    put_request(mk(CMD_TICK, 8'h00, 8'h00, 8'h00, 1'b0));
    foreach (burst[i]) put_request(mk(CMD_LOAD, burst[i], 8'h00, 8'h00, 1'b0));
    put_request(mk(CMD_TICK, 8'h00, 8'h00, 8'h00, 1'b0));

    // Random phases run through the register extremes, including the zero
    // retry limit and the zero timeout, and then through short timeouts and
    // low retry limits that make failures frequent. Phase three sends without
    // any gaps.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          mask = 8'hff; retries = 4'd15; ticks = 16'hffff;
        end
        1: begin
          mask = 8'h00; retries = 4'd1; ticks = 16'd1;
        end
        2: begin
          mask = 8'($urandom_range(0, 255)); retries = 4'd0; ticks = 16'd0;
        end
        default: begin
          mask    = 8'($urandom_range(0, 255));
          retries = 4'($urandom_range(1, 4));
          ticks   = 16'($urandom_range(1, 6));
        end
      endcase
      settle();
      apply_config(mask, retries, ticks);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (ph != 3 && $urandom_range(0, 99) < 32) begin
          start_i <= 1'b0;
          repeat ($urandom_range(1, 6)) @(posedge clk_i);
        end
        put_request(next_request());
      end
    end

    settle();
    if (sb.errors == 0) begin
      $display("segment_transfer_arq_server regression: pass");
    end else begin
      $display("segment_transfer_arq_server regression: fail");
    end
    $finish;
  end

endmodule
